// ===== design/csf_pkg.sv =====
// Shared types and constants for the cubic spline coefficient fitter.
package csf_pkg;

  // Run length limit and derived counter width
  localparam int MAX_SHIFTS = 16;
  localparam int CNT_W      = $clog2(MAX_SHIFTS + 1);

  // Field widths
  localparam int SAMPLE_W = 16;
  localparam int INV_W    = 16;
  localparam int COEF_W   = 32;
  localparam int SEG_W    = 4;

  // Doubled coefficients before scaling fit comfortably in 22 signed bits
  localparam int X2_W   = 22;
  localparam int PROD_W = X2_W + INV_W + 1;
  localparam int FRAC_W = 16;

  // Clamp level 2.0 in Q3.12 and reset value 1.0 in Q1.15
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_CAP = 16'sd8192;
  localparam logic [INV_W-1:0]           INV_RESET  = 16'h8000;

  // Job queue geometry
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_INV_STRIDE      = 2'd0,
    CFG_INV_STRIDE_SQ   = 2'd1,
    CFG_INV_STRIDE_CUBE = 2'd2
  } cfg_idx_t;

  typedef logic signed [X2_W-1:0] x2_t;

  // One segment awaiting scaling: coefficients held at twice their value
  typedef struct packed {
    x2_t                         a2;
    x2_t                         b2;
    x2_t                         c2;
    logic signed [SAMPLE_W-1:0]  d;
    logic [SEG_W-1:0]            seg;
    logic                        last;
    logic                        err;
  } job_t;

  // Up to two jobs handed over by the front end in one cycle
  typedef struct packed {
    logic push0;
    logic push1;
    job_t job0;
    job_t job1;
  } push_t;

endpackage

// ===== design/csf_front.sv =====
// Front end: sample window, run tracking and segment classification.
module csf_front (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  take,
  input  logic signed [csf_pkg::SAMPLE_W-1:0]   sample,
  input  logic                                  last_of_bin,
  output csf_pkg::push_t                        push
);

  logic signed [csf_pkg::SAMPLE_W-1:0] w0, w1, w2;
  logic signed [csf_pkg::SAMPLE_W-1:0] w0_next, w1_next, w2_next;
  logic [csf_pkg::CNT_W-1:0]           count, count_next;
  logic                                overflowed, overflowed_next;

  logic signed [csf_pkg::SAMPLE_W-1:0] s_c;
  csf_pkg::x2_t                        y0, y1, y2, ys, m_a, m_b;
  csf_pkg::job_t                       err_job, lin_job, quad_job, cub_job, fin_job;
  csf_pkg::push_t                      push_raw;
  logic                                ov, run_end;

  // Clamp the incoming word at 2.0
  always_comb begin
    s_c = (sample > csf_pkg::SAMPLE_CAP) ? csf_pkg::SAMPLE_CAP : sample;
  end

  // Form every candidate segment from the window and the new word
  always_comb begin
    y0  = csf_pkg::X2_W'(w0);
    y1  = csf_pkg::X2_W'(w1);
    y2  = csf_pkg::X2_W'(w2);
    ys  = csf_pkg::X2_W'(s_c);
    m_a = y2 - y0;
    m_b = ys - y1;

    err_job      = '0;
    err_job.last = 1'b1;
    err_job.err  = 1'b1;

    // Two-sample run: one linear segment
    lin_job      = '0;
    lin_job.c2   = (ys - y2) <<< 1;
    lin_job.d    = w2;
    lin_job.last = 1'b1;

    // First segment: quadratic with one-sided slope
    quad_job     = '0;
    quad_job.b2  = (y1 <<< 1) - (y2 <<< 1) + m_b;
    quad_job.c2  = -(y1 <<< 2) + (y2 <<< 2) - m_b;
    quad_job.d   = w1;

    // Middle segment: cubic Hermite, central-difference slopes
    cub_job      = '0;
    cub_job.a2   = (y1 <<< 2) - (y2 <<< 2) + m_a + m_b;
    cub_job.b2   = -((y1 <<< 2) + (y1 <<< 1)) + ((y2 <<< 2) + (y2 <<< 1))
                   - (m_a <<< 1) - m_b;
    cub_job.c2   = m_a;
    cub_job.d    = w1;
    cub_job.seg  = csf_pkg::SEG_W'(count - csf_pkg::CNT_W'(2));

    // Closing segment: quadratic
    fin_job      = '0;
    fin_job.b2   = -(y2 <<< 1) + (ys <<< 1) - m_b;
    fin_job.c2   = m_b;
    fin_job.d    = w2;
    fin_job.seg  = csf_pkg::SEG_W'(count - csf_pkg::CNT_W'(1));
    fin_job.last = 1'b1;
  end

  // Classify the word and choose the jobs and the next run state
  always_comb begin
    push_raw        = '0;
    run_end         = 1'b0;
    overflowed_next = overflowed;
    ov = overflowed || (count >= csf_pkg::CNT_W'(csf_pkg::MAX_SHIFTS));

    if (ov) begin
      overflowed_next = 1'b1;
      if (last_of_bin) begin
        push_raw.push0 = 1'b1;
        push_raw.job0  = err_job;
        run_end        = 1'b1;
      end
    end else if (count == '0) begin
      if (last_of_bin) begin
        push_raw.push0 = 1'b1;
        push_raw.job0  = err_job;
        run_end        = 1'b1;
      end
    end else if (count == csf_pkg::CNT_W'(1)) begin
      if (last_of_bin) begin
        push_raw.push0 = 1'b1;
        push_raw.job0  = lin_job;
        run_end        = 1'b1;
      end
    end else begin
      push_raw.push0 = 1'b1;
      push_raw.job0  = (count == csf_pkg::CNT_W'(2)) ? quad_job : cub_job;
      if (last_of_bin) begin
        push_raw.push1 = 1'b1;
        push_raw.job1  = fin_job;
        run_end        = 1'b1;
      end
    end

    if (run_end) begin
      w0_next         = '0;
      w1_next         = '0;
      w2_next         = '0;
      count_next      = '0;
      overflowed_next = 1'b0;
    end else if (ov) begin
      w0_next    = w0;
      w1_next    = w1;
      w2_next    = w2;
      count_next = count;
    end else begin
      w0_next    = w1;
      w1_next    = w2;
      w2_next    = s_c;
      count_next = count + csf_pkg::CNT_W'(1);
    end
  end

  // Hand jobs over only for an accepted word
  always_comb begin
    push       = push_raw;
    push.push0 = push_raw.push0 & take;
    push.push1 = push_raw.push1 & take;
  end

  // Advance the run state on each accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      w0         <= '0;
      w1         <= '0;
      w2         <= '0;
      count      <= '0;
      overflowed <= 1'b0;
    end else if (take) begin
      w0         <= w0_next;
      w1         <= w1_next;
      w2         <= w2_next;
      count      <= count_next;
      overflowed <= overflowed_next;
    end
  end

  // A closing word always leaves an empty run behind
  a_run_clears: assert property (@(posedge clk) disable iff (rst)
    take && last_of_bin |=> count == '0 && !overflowed)
    else $error("run state not cleared after closing word");

  // The count never passes the run limit
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= csf_pkg::CNT_W'(csf_pkg::MAX_SHIFTS))
    else $error("sample count beyond limit");

endmodule

// ===== design/csf_queue.sv =====
// Short job queue between front and back: two writes, one read per cycle.
module csf_queue (
  input  logic           clk,
  input  logic           rst,
  input  csf_pkg::push_t push,
  input  logic           pop,
  output logic           space,
  output logic           nonempty,
  output csf_pkg::job_t  head
);

  csf_pkg::job_t              mem [csf_pkg::QDEPTH];
  logic [csf_pkg::QPTR_W-1:0] wptr, rptr;
  logic [csf_pkg::QCNT_W-1:0] count;

  // Room for two jobs regardless of this cycle's read
  assign space    = count <= csf_pkg::QCNT_W'(csf_pkg::QDEPTH - 2);
  assign nonempty = count != '0;
  assign head     = mem[rptr];

  // Store incoming jobs
  always_ff @(posedge clk) begin
    if (push.push0) begin
      mem[wptr] <= push.job0;
    end
    if (push.push1) begin
      mem[wptr + csf_pkg::QPTR_W'(1)] <= push.job1;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + csf_pkg::QPTR_W'(push.push0) + csf_pkg::QPTR_W'(push.push1);
      rptr  <= rptr + csf_pkg::QPTR_W'(pop);
      count <= count + csf_pkg::QCNT_W'(push.push0) + csf_pkg::QCNT_W'(push.push1)
               - csf_pkg::QCNT_W'(pop);
    end
  end

  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    count <= csf_pkg::QCNT_W'(csf_pkg::QDEPTH))
    else $error("job queue overfilled");

  a_push_order: assert property (@(posedge clk) disable iff (rst)
    push.push1 |-> push.push0)
    else $error("second job pushed without first");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> nonempty)
    else $error("pop from empty job queue");

endmodule

// ===== design/csf_back.sv =====
// Back end: stride scaling, rounding and the output register.
module csf_back (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  input  logic [1:0]                           cfg_index,
  input  logic [csf_pkg::INV_W-1:0]            cfg_data,
  input  logic                                 nonempty,
  input  csf_pkg::job_t                        head,
  output logic                                 pop,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [csf_pkg::COEF_W-1:0]    coef_cubic,
  output logic signed [csf_pkg::COEF_W-1:0]    coef_square,
  output logic signed [csf_pkg::COEF_W-1:0]    coef_linear,
  output logic signed [csf_pkg::COEF_W-1:0]    coef_const,
  output logic [csf_pkg::SEG_W-1:0]            segment,
  output logic                                 last_of_run,
  output logic                                 error
);

  logic [csf_pkg::INV_W-1:0] inv_stride, inv_stride_sq, inv_stride_cube;
  logic                      advance;

  // Multiply by the reciprocal, round half up, drop the 16 fraction bits.
  // Inputs stay within 22 bits, so the result never reaches the 32-bit limits.
  function automatic logic signed [csf_pkg::COEF_W-1:0] scale(
    input csf_pkg::x2_t              x,
    input logic [csf_pkg::INV_W-1:0] inv
  );
    logic signed [csf_pkg::PROD_W-1:0] prod;
    logic signed [csf_pkg::PROD_W-1:0] rnd;
    prod  = csf_pkg::PROD_W'(x) * csf_pkg::PROD_W'($signed({1'b0, inv}));
    rnd   = prod + csf_pkg::PROD_W'(1 <<< (csf_pkg::FRAC_W - 1));
    scale = csf_pkg::COEF_W'($signed(rnd[csf_pkg::PROD_W-1:csf_pkg::FRAC_W]));
  endfunction

  // Hold the stride reciprocals
  always_ff @(posedge clk) begin
    if (rst) begin
      inv_stride      <= csf_pkg::INV_RESET;
      inv_stride_sq   <= csf_pkg::INV_RESET;
      inv_stride_cube <= csf_pkg::INV_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        csf_pkg::CFG_INV_STRIDE:      inv_stride      <= cfg_data;
        csf_pkg::CFG_INV_STRIDE_SQ:   inv_stride_sq   <= cfg_data;
        csf_pkg::CFG_INV_STRIDE_CUBE: inv_stride_cube <= cfg_data;
        default: ;
      endcase
    end
  end

  // Take the next job whenever the output register is free or drains
  assign advance = !out_valid || out_ready;
  assign pop     = advance && nonempty;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= nonempty;
    end
  end

  // Load the scaled word
  always_ff @(posedge clk) begin
    if (pop) begin
      coef_cubic  <= scale(head.a2, inv_stride_cube);
      coef_square <= scale(head.b2, inv_stride_sq);
      coef_linear <= scale(head.c2, inv_stride);
      coef_const  <= csf_pkg::COEF_W'(head.d);
      segment     <= head.seg;
      last_of_run <= head.last;
      error       <= head.err;
    end
  end

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && error |-> coef_cubic == '0 && coef_square == '0 &&
                           coef_linear == '0 && coef_const == '0 && last_of_run)
    else $error("error word carries coefficients");

endmodule

// ===== design/cubic_spline_coefficient_fit.sv =====
// Top level of the cubic spline coefficient fitter.
// A job from an accepted word is written into the job queue, then loaded into the output register.
// The front end takes one sample word per cycle while the job queue has room; a closing
// word with two segments yields two output words, as the back end takes one job at a time.
// Reset clears the run window, job queue and output valid, and sets strides to 1.0.
module cubic_spline_coefficient_fit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [csf_pkg::SAMPLE_W-1:0]  sample,
  input  logic                                 last_of_bin,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [csf_pkg::COEF_W-1:0]    coef_cubic,
  output logic signed [csf_pkg::COEF_W-1:0]    coef_square,
  output logic signed [csf_pkg::COEF_W-1:0]    coef_linear,
  output logic signed [csf_pkg::COEF_W-1:0]    coef_const,
  output logic [csf_pkg::SEG_W-1:0]            segment,
  output logic                                 last_of_run,
  output logic                                 error,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [1:0]                           cfg_index,
  input  logic [csf_pkg::INV_W-1:0]            cfg_data
);

  csf_pkg::push_t push;
  csf_pkg::job_t  head;
  logic           space, nonempty, pop, take;

  assign in_ready  = space;
  assign cfg_ready = 1'b1;
  assign take      = in_valid && space;

  csf_front u_front (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .sample      (sample),
    .last_of_bin (last_of_bin),
    .push        (push)
  );

  csf_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .pop      (pop),
    .space    (space),
    .nonempty (nonempty),
    .head     (head)
  );

  csf_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .nonempty    (nonempty),
    .head        (head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .coef_cubic  (coef_cubic),
    .coef_square (coef_square),
    .coef_linear (coef_linear),
    .coef_const  (coef_const),
    .segment     (segment),
    .last_of_run (last_of_run),
    .error       (error)
  );

endmodule
